// ----- design/iprt_pkg.sv -----
// Package for the IPv4 longest-prefix-match route table.
// Holds beat and entry types, operation and status codes, and mask helpers.
// No dependencies.
`timescale 1ns / 1ps
package iprt_pkg;

    localparam int ADDR_W = 32;
    localparam int LEN_W  = 6;
    localparam int PORT_W = 16;

    // Operation codes carried in the op field
    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_DELETE = 2'd2
    } t_op;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    // Controller states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_WRITE,
        S_DONE
    } t_state;

    // Input beat
    typedef struct packed {
        logic [1:0]        op;
        logic [ADDR_W-1:0] address;
        logic [LEN_W-1:0]  prefix_len;
        logic [PORT_W-1:0] if_index;
        logic [ADDR_W-1:0] next_hop;
    } t_in_item;

    // Output beat
    typedef struct packed {
        logic [1:0]        status;
        logic              hit;
        logic [ADDR_W-1:0] route_next_hop;
        logic [PORT_W-1:0] route_if_index;
        logic [LEN_W-1:0]  route_len;
    } t_out_item;

    // One table slot as held in memory
    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] prefix;
        logic [LEN_W-1:0]  len;
        logic [ADDR_W-1:0] hop;
        logic [PORT_W-1:0] port;
    } t_entry;

    // Controller to datapath commands
    typedef struct packed {
        logic load;    // latch the accepted input beat
        logic rd;      // read the slot at the scan address
        logic clr;     // zero the slot at the scan address
        logic commit;  // write the chosen slot for an insert
        logic finish;  // load the result register
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic is_insert;  // latched operation is an insert
        logic out_free;   // result register can take a new beat
    } t_sts;

    // Big-endian prefix mask; length 0 gives no bits, 32 and above all bits
    function automatic logic [ADDR_W-1:0] len_mask(input logic [LEN_W-1:0] len);
        logic [ADDR_W-1:0] m;
        m = '0;
        if (len == '0) begin
            m = '0;
        end else if (len >= LEN_W'(ADDR_W)) begin
            m = '1;
        end else begin
            m = {ADDR_W{1'b1}} << (LEN_W'(ADDR_W) - len);
        end
        return m;
    endfunction

    // Clamp a prefix length to the address width
    function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W-1:0] len);
        return (len > LEN_W'(ADDR_W)) ? LEN_W'(ADDR_W) : len;
    endfunction

endpackage

// ----- design/iprt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module iprt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/iprt_ctrl.sv -----
// Controller for the route table: clearing pass, slot scan, insert write, result.
// Depends on iprt_pkg.
`timescale 1ns / 1ps
module iprt_ctrl #(
    parameter int TABLE_DEPTH = 16,
    parameter int AW          = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  iprt_pkg::t_sts i_sts,
    output iprt_pkg::t_cmd o_cmd,
    output logic [AW-1:0]  o_addr
);
    import iprt_pkg::*;

    localparam int SW = $clog2(TABLE_DEPTH + 1);

    t_state        r_state, n_state;
    logic [SW-1:0] r_step,  n_step;

    // State and step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    assign o_addr = r_step[AW-1:0];

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                n_step    = r_step + SW'(1);
                if (r_step == SW'(TABLE_DEPTH - 1)) begin
                    n_state = S_IDLE;
                    n_step  = '0;
                end
            end
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_step     = '0;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                // reads go out at steps 0..depth-1, last data is judged at step depth
                if (r_step == SW'(TABLE_DEPTH)) begin
                    n_step  = '0;
                    n_state = i_sts.is_insert ? S_WRITE : S_DONE;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_step   = r_step + SW'(1);
                end
            end
            S_WRITE: begin
                o_cmd.commit = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_step  = '0;
            end
        endcase
    end

endmodule

// ----- design/iprt_dp.sv -----
// Datapath for the route table: slot memory, per-slot compare, best match, result.
// Depends on iprt_pkg and iprt_ram.
`timescale 1ns / 1ps
module iprt_dp #(
    parameter int TABLE_DEPTH = 16,
    parameter int AW          = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  iprt_pkg::t_cmd      i_cmd,
    input  logic [AW-1:0]       i_addr,
    input  iprt_pkg::t_in_item  i_in_data,
    output iprt_pkg::t_sts      o_sts,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output iprt_pkg::t_out_item o_out_data
);
    import iprt_pkg::*;

    // Latched operation
    logic [1:0]        r_op;
    logic [ADDR_W-1:0] r_addr;
    logic [ADDR_W-1:0] r_pfx;
    logic [LEN_W-1:0]  r_len;
    logic [PORT_W-1:0] r_port;
    logic [ADDR_W-1:0] r_hop;

    // Scan bookkeeping
    logic              r_q_vld;
    logic [AW-1:0]     r_q_idx;
    logic              r_found;
    logic [AW-1:0]     r_found_idx;
    logic              r_free;
    logic [AW-1:0]     r_free_idx;
    logic              r_any;
    logic              r_best;
    logic [ADDR_W-1:0] r_best_hop;
    logic [PORT_W-1:0] r_best_port;
    logic [LEN_W-1:0]  r_best_len;

    logic              r_out_valid;
    t_out_item         r_out, n_out;

    t_entry            q;
    logic [$bits(t_entry)-1:0] ram_rdata;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    t_entry            ram_wdata;
    logic              exact;
    logic              covers;
    logic              del_hit;
    logic              slot_ok;
    logic [LEN_W-1:0]  in_len;

    iprt_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.rd),
        .i_raddr (i_addr),
        .o_rdata (ram_rdata)
    );

    assign q      = t_entry'(ram_rdata);
    assign in_len = sat_len(i_in_data.prefix_len);

    // Slot compares on the beat read back from memory
    assign exact   = q.valid && (q.prefix == r_pfx) && (q.len == r_len);
    assign covers  = q.valid && ((r_addr & len_mask(q.len)) == q.prefix);
    assign del_hit = r_q_vld && (r_op == OP_DELETE) && exact;
    assign slot_ok = r_found || r_free;

    // Memory write: clearing pass, delete of a matching slot, or insert commit
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_q_idx;
        ram_wdata = '0;
        if (i_cmd.clr) begin
            ram_we    = 1'b1;
            ram_waddr = i_addr;
        end else if (i_cmd.commit) begin
            ram_we    = slot_ok;
            ram_waddr = r_found ? r_found_idx : r_free_idx;
            ram_wdata = '{valid: 1'b1, prefix: r_pfx, len: r_len, hop: r_hop, port: r_port};
        end else if (del_hit) begin
            ram_we = 1'b1;
        end
    end

    // Read pipeline tag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_vld <= 1'b0;
        end else begin
            r_q_vld <= i_cmd.rd;
        end
        r_q_idx <= i_addr;
    end

    // Latch the beat and run the scan
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_in_data.op;
            r_addr  <= i_in_data.address;
            r_len   <= in_len;
            r_pfx   <= i_in_data.address & len_mask(in_len);
            r_port  <= i_in_data.if_index;
            r_hop   <= i_in_data.next_hop;
            r_found <= 1'b0;
            r_free  <= 1'b0;
            r_any   <= 1'b0;
            r_best  <= 1'b0;
        end else if (r_q_vld) begin
            // insert: first exact slot, else first free slot
            if (r_op == OP_INSERT) begin
                if (exact && !r_found) begin
                    r_found     <= 1'b1;
                    r_found_idx <= r_q_idx;
                end
                if (!q.valid && !r_free) begin
                    r_free     <= 1'b1;
                    r_free_idx <= r_q_idx;
                end
            end
            // lookup: strictly longer wins, so the lowest index keeps ties
            if ((r_op == OP_LOOKUP) && covers && (!r_best || (q.len > r_best_len))) begin
                r_best      <= 1'b1;
                r_best_hop  <= q.hop;
                r_best_port <= q.port;
                r_best_len  <= q.len;
            end
            if (del_hit) begin
                r_any <= 1'b1;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result beat for the finished operation
    always_comb begin
        n_out = '{status: ST_MISS, hit: 1'b0, route_next_hop: '0,
                  route_if_index: '0, route_len: '0};
        case (r_op)
            OP_INSERT: begin
                n_out.status = slot_ok ? ST_OK : ST_FULL;
            end
            OP_LOOKUP: begin
                if (r_best) begin
                    n_out = '{status: ST_OK, hit: 1'b1, route_next_hop: r_best_hop,
                              route_if_index: r_best_port, route_len: r_best_len};
                end
            end
            OP_DELETE: begin
                n_out.status = r_any ? ST_OK : ST_MISS;
            end
            default: begin
                n_out.status = ST_MISS;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_data      = r_out;
    assign o_sts.is_insert = (r_op == OP_INSERT);
    assign o_sts.out_free  = !r_out_valid || !i_out_stall;

endmodule

// ----- design/ipv4_route_table_lpm.sv -----
// IPv4 longest-prefix-match route table, top level.
// Each operation is latched, scanned over every slot, written for an insert, then
// loaded into the result register; a new one is taken only after that, and the scan
// reads one slot per cycle through the single read port of the slot memory.
// Reset: synchronous; a clearing pass over every slot follows, input stalled.
// Depends on iprt_pkg, iprt_ctrl, iprt_dp.
`timescale 1ns / 1ps
module ipv4_route_table_lpm #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  iprt_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output iprt_pkg::t_out_item o_out_data
);
    import iprt_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    t_cmd          cmd;
    t_sts          sts;
    logic [AW-1:0] scan_addr;

    iprt_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .AW          (AW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_addr     (scan_addr)
    );

    iprt_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .AW          (AW)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_addr      (scan_addr),
        .i_in_data   (i_in_data),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
